FILE: hdl/bda_pkg.sv
package bda_pkg;

  // Width of the binary number; the value port carries at most 16 bits
  localparam int VALUE_BITS = 16;
  localparam int IN_BITS    = 16;
  localparam int EFF_BITS   = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;

  // floor(n * log10(2)) + 1 decimal digits cover any n-bit value
  localparam int DIGITS     = (EFF_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS   = DIGITS * 4;
  localparam int STEP_W     = (EFF_BITS > 1) ? $clog2(EFF_BITS) : 1;
  localparam int LEFT_W     = $clog2(DIGITS + 1);
  localparam int CHAR_BITS  = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(8'h30);

  typedef struct packed {
    logic load;   // take a new word, clear the digits
    logic conv;   // one shift-and-add-3 step
    logic shift;  // drop the top digit
    logic emit;   // present the top digit, then drop it
  } bda_cmd_t;

  typedef struct packed {
    logic conv_done;  // current step is the last conversion step
    logic top_zero;   // top digit is zero
    logic one_left;   // only one digit remains
  } bda_sts_t;

endpackage

FILE: hdl/bda_ctrl.sv
module bda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  input  bda_pkg::bda_sts_t sts,
  output bda_pkg::bda_cmd_t cmd
);
  import bda_pkg::*;

  typedef enum logic [1:0] {IDLE, CONV, SKIP, EMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = CONV;
        end
      end
      CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_done) state_nxt = SKIP;
      end
      SKIP: begin
        // drop leading zeros, but always keep the last digit
        if (sts.top_zero && !sts.one_left) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sts.one_left ? IDLE : EMIT;
        end
      end
      EMIT: begin
        cmd.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        if (sts.one_left) state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != IDLE);
  assign out_valid = out_valid_r;

  a_strobe_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == SKIP || $past(state_r) == EMIT))
    else $error("strobe without an output state");

  a_start_enters_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == CONV))
    else $error("accepted word did not start conversion");

  a_conv_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CONV && !sts.conv_done) |=> (state_r == CONV))
    else $error("conversion left early");

endmodule

FILE: hdl/bda_dp.sv
module bda_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bda_pkg::IN_BITS-1:0]      in_value,
  input  bda_pkg::bda_cmd_t                cmd,
  output bda_pkg::bda_sts_t                sts,
  output logic [bda_pkg::CHAR_BITS-1:0]    out_digit_char,
  output logic                             out_last_digit
);
  import bda_pkg::*;

  logic [EFF_BITS-1:0]  bin_r;
  logic [BCD_BITS-1:0]  bcd_r;
  logic [BCD_BITS-1:0]  bcd_adj;
  logic [STEP_W-1:0]    step_r;
  logic [LEFT_W-1:0]    left_r;
  logic [CHAR_BITS-1:0] char_r;
  logic                 last_r;
  logic [3:0]           top_nib;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  assign top_nib = bcd_r[BCD_BITS-1 -: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= in_value[EFF_BITS-1:0];
      bcd_r  <= '0;
      step_r <= '0;
      left_r <= LEFT_W'(DIGITS);
    end else if (cmd.conv) begin
      {bcd_r, bin_r} <= {bcd_adj[BCD_BITS-2:0], bin_r, 1'b0};
      step_r         <= step_r + 1'b1;
    end else if (cmd.shift || cmd.emit) begin
      bcd_r  <= {bcd_r[BCD_BITS-5:0], 4'd0};
      left_r <= left_r - 1'b1;
    end
    if (cmd.emit) begin
      char_r <= ASCII_ZERO + {{(CHAR_BITS-4){1'b0}}, top_nib};
      last_r <= sts.one_left;
    end
  end

  assign sts.conv_done  = (step_r == STEP_W'(EFF_BITS - 1));
  assign sts.top_zero   = (top_nib == 4'd0);
  assign sts.one_left   = (left_r == LEFT_W'(1));
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (top_nib <= 4'd9))
    else $error("emitted digit is not decimal");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (bcd_r == '0 && step_r == '0))
    else $error("load did not clear the digits");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (char_r >= CHAR_BITS'(48) && char_r <= CHAR_BITS'(57)))
    else $error("character out of the digit range");

endmodule

FILE: hdl/binary_to_decimal_ascii.sv
// channel  ports                                 handshake
// input    in_value                              taken when start && !busy
// result   out_digit_char, out_last_digit        one cycle, marked by out_valid
//
// A word is loaded and then takes 16 shift-and-add-3 steps (one per value
// bit, set by the conversion loop in bda_dp); the five digit positions are
// then visited in turn, each either dropped as a leading zero or sent.
// busy falls in the cycle the last digit is shown, so the next start may
// overlap that strobe. Reset (rst_n, synchronous) returns the controller to
// idle and drops the strobe. The receiver cannot stall: each digit is shown
// for exactly one cycle.
module binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bda_pkg::IN_BITS-1:0]   in_value,
  output logic                          out_valid,
  output logic [bda_pkg::CHAR_BITS-1:0] out_digit_char,
  output logic                          out_last_digit
);
  import bda_pkg::*;

  bda_cmd_t cmd;
  bda_sts_t sts;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bda_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

FILE: tb/sv/binary_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;
  import bda_pkg::*;

  localparam int unsigned WORD_COUNT = 500;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned VALUE_MASK = (32'd1 << EFF_BITS) - 32'd1;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } digit_t;

  class digit_scoreboard;
    digit_t      pending[$];
    int unsigned words;
    int unsigned digits;
    int unsigned errors;
    int unsigned by_len[1:5];

    function void report_error(string what, digit_t exp_d, digit_t got_d);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                 $realtime, what, exp_d.ch, exp_d.last, got_d.ch, got_d.last);
      end
    endfunction

    // expand the word into its decimal characters, most significant first
    function void note_word(logic [IN_BITS-1:0] v);
      int unsigned n;
      int unsigned dec[$];
      digit_t      e;
      n = 32'(v) & VALUE_MASK;
      do begin
        dec.push_front(n % 10);
        n = n / 10;
      end while (n != 0);
      foreach (dec[k]) begin
        e.ch   = ASCII_ZERO + CHAR_BITS'(dec[k]);
        e.last = (k == dec.size() - 1);
        pending.push_back(e);
      end
      if (dec.size() <= 5) by_len[dec.size()]++;
      words++;
    endfunction

    function void check_digit(logic [CHAR_BITS-1:0] ch, logic last);
      digit_t got_d;
      digit_t exp_d;
      got_d.ch   = ch;
      got_d.last = last;
      digits++;
      if (pending.size() == 0) begin
        exp_d = '0;
        report_error("unexpected digit", exp_d, got_d);
      end else begin
        exp_d = pending.pop_front();
        if (exp_d.ch !== got_d.ch || exp_d.last !== got_d.last)
          report_error("digit mismatch", exp_d, got_d);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [IN_BITS-1:0]   in_value;
  logic                 out_valid;
  logic [CHAR_BITS-1:0] out_digit_char;
  logic                 out_last_digit;

  digit_scoreboard sb;
  int unsigned     idle_cycles;
  int unsigned     sent;

  binary_to_decimal_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  always #6 clk = ~clk;

  // sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_word(in_value);
    if (rst_n && out_valid) sb.check_digit(out_digit_char, out_last_digit);
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // hold start high until the word is taken, return on the next falling edge
  task automatic drive_word(input logic [IN_BITS-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start    <= 1'b0;
      in_value <= IN_BITS'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [IN_BITS-1:0] pick_value();
    int unsigned lo;
    int unsigned hi;
    int unsigned nd;
    case ($urandom_range(0, 3))
      0: pick_value = IN_BITS'($urandom);
      1: begin
        // spread evenly over digit counts
        nd = $urandom_range(1, 5);
        lo = (nd == 1) ? 0 : 10 ** (nd - 1);
        hi = (10 ** nd) - 1;
        if (hi > 65535) hi = 65535;
        pick_value = IN_BITS'($urandom_range(lo, hi));
      end
      2: begin
        // land next to a power of ten
        nd = $urandom_range(1, 4);
        pick_value = IN_BITS'((10 ** nd) + $urandom_range(0, 2) - 1);
      end
      default: pick_value = IN_BITS'($urandom_range(0, 20));
    endcase
  endfunction

  initial begin
    logic [IN_BITS-1:0] directed[$];
    sb          = new;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_value    = '0;
    idle_cycles = 0;
    sent        = 0;
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'hAAAA, 16'h5555,
                 16'h8000, 16'h7FFF, 16'd12345, 16'd50000, 16'd0, 16'd7};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      drive_word(directed[i]);
      if (i % 4 == 3) pause($urandom_range(1, 25));
    end

    while (sent < WORD_COUNT) begin
      repeat ($urandom_range(1, 10)) drive_word(pick_value());
      case ($urandom_range(0, 3))
        0: pause(0);
        1: pause($urandom_range(1, 5));
        default: pause($urandom_range(1, 30));
      endcase
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("converted %0d words into %0d digits; by digit count 1..5: %0d %0d %0d %0d %0d",
             sb.words, sb.digits, sb.by_len[1], sb.by_len[2], sb.by_len[3],
             sb.by_len[4], sb.by_len[5]);
    $display("errors: %0d, digits still owed: %0d", sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bda_pkg.sv
hdl/bda_ctrl.sv
hdl/bda_dp.sv
hdl/binary_to_decimal_ascii.sv
tb/sv/binary_to_decimal_ascii_test.sv
